// ----- rtl/core/pcpa_pkg.sv -----
// Shared constants, types and helper functions of the per-CPU page allocator.
package pcpa_pkg;

  localparam int NUM_CPUS   = 8;
  localparam int NUM_PAGES  = 32768;
  localparam int PAGE_BYTES = 4096;

  localparam int ADDR_W   = 32;
  localparam int CPU_IN_W = 3;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;

  localparam int CPU_W   = $clog2(NUM_CPUS);
  localparam int FRAME_W = $clog2(NUM_PAGES);
  localparam int PAGE_W  = $clog2(PAGE_BYTES);
  localparam int PN_W    = ADDR_W - PAGE_W;
  localparam int LINK_W  = FRAME_W + 1;

  localparam int CPU_RW = ((CPU_IN_W > CPU_W) ? CPU_IN_W : CPU_W) + 1;
  localparam int CPU_RED_STEPS = (2 ** CPU_IN_W) / NUM_CPUS;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_END   = 1'b1;

  localparam logic [ADDR_W-1:0] REGION_START_RST = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] REGION_END_RST   = 32'h8800_0000;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  typedef struct packed {
    logic               ok;
    logic [FRAME_W-1:0] frame;
  } free_chk_t;

  typedef struct packed {
    logic               found;
    logic [CPU_W-1:0]   cpu;
    logic [FRAME_W-1:0] frame;
  } head_sel_t;

  typedef struct packed {
    logic               push;
    logic               pop;
    logic [CPU_W-1:0]   cpu;
    logic [FRAME_W-1:0] frame;
    logic               valid;
  } head_upd_t;

  function automatic logic [CPU_W-1:0] cpu_reduce(input logic [CPU_IN_W-1:0] c);
    logic [CPU_RW-1:0] v;
    v = CPU_RW'(c);
    for (int k = 0; k < CPU_RED_STEPS; k++) begin
      if (v >= CPU_RW'(NUM_CPUS)) begin
        v = v - CPU_RW'(NUM_CPUS);
      end
    end
    return CPU_W'(v);
  endfunction

  // Page number of region_start rounded up to a page; the top bit flags overflow.
  function automatic logic [PN_W:0] page_base(input logic [ADDR_W-1:0] s);
    return {1'b0, s[ADDR_W-1:PAGE_W]} + (PN_W + 1)'(|s[PAGE_W-1:0]);
  endfunction

endpackage

// ----- rtl/core/pcpa_link_ram.sv -----
// Single-port-write, single-port-read synchronous RAM holding the free-list links.
module pcpa_link_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/pcpa_free_check.sv -----
// Validates a freed page address against the region and converts it to a frame index.
module pcpa_free_check import pcpa_pkg::*; (
  input  logic [ADDR_W-1:0] region_start,
  input  logic [ADDR_W-1:0] region_end,
  input  logic [ADDR_W-1:0] page_addr,
  output free_chk_t         chk
);

  logic [PN_W:0]     base_pn;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] diff;
  logic              in_range;

  always_comb begin
    base_pn  = page_base(region_start);
    base     = {base_pn[PN_W-1:0], PAGE_W'(0)};
    diff     = page_addr - base;
    in_range = (page_addr >= region_start) && (page_addr < region_end) &&
               (page_addr >= base) && !base_pn[PN_W];
    chk.ok   = (page_addr[PAGE_W-1:0] == '0) && in_range &&
               ((ADDR_W + 1)'(diff >> PAGE_W) < (ADDR_W + 1)'(NUM_PAGES));
    chk.frame = FRAME_W'(diff >> PAGE_W);
  end

endmodule

// ----- rtl/core/pcpa_heads.sv -----
// Per-CPU list head registers with own-list or lowest-CPU steal selection.
module pcpa_heads import pcpa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             op,
  input  logic [CPU_W-1:0] cpu,
  input  head_upd_t        upd,
  output head_sel_t        sel
);

  logic [FRAME_W-1:0] head_frame [NUM_CPUS];
  logic [NUM_CPUS-1:0] head_valid;
  logic [CPU_W-1:0]    pick;
  logic                hit;
  logic [CPU_W-1:0]    rd_idx;

  always_comb begin
    pick = cpu;
    hit  = head_valid[cpu];
    if (!head_valid[cpu]) begin
      for (int i = NUM_CPUS - 1; i >= 0; i--) begin
        if (head_valid[i] && (CPU_W'(i) != cpu)) begin
          pick = CPU_W'(i);
          hit  = 1'b1;
        end
      end
    end
    rd_idx    = (op == OP_FREE) ? cpu : pick;
    sel.cpu   = rd_idx;
    sel.frame = head_frame[rd_idx];
    sel.found = (op == OP_FREE) ? head_valid[cpu] : hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= '0;
    end else if (upd.push) begin
      head_valid[upd.cpu] <= 1'b1;
    end else if (upd.pop) begin
      head_valid[upd.cpu] <= upd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.push || upd.pop) begin
      head_frame[upd.cpu] <= upd.frame;
    end
  end

endmodule

// ----- rtl/core/per_cpu_page_free_list_allocator.sv -----
// Top level of the per-CPU page allocator: control sequencer, link memory and result register.
// A free, or an allocate that finds every list empty, loads its result register in the execute
// state; a popping allocate loads it in the following read state, the synchronous read of the
// link memory at the popped list head. One item is in work at a time: a new one is taken only
// when the last is through, even while the previous result still waits in the output register.
// Reset empties every list and loads the region registers; the link memory is not cleared.
module per_cpu_page_free_list_allocator import pcpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [ADDR_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  input  logic [CPU_IN_W-1:0]  cpu,
  input  logic [ADDR_W-1:0]    page_addr,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ADDR_W-1:0]    alloc_addr,
  output logic [STATUS_W-1:0]  status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  state_t state;
  state_t state_next;

  logic [ADDR_W-1:0]  region_start;
  logic [ADDR_W-1:0]  region_end;
  logic               op_q;
  logic [CPU_W-1:0]   cpu_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [CPU_W-1:0]   pop_cpu;
  logic [FRAME_W-1:0] pop_frame;

  free_chk_t  chk;
  head_sel_t  sel;
  head_upd_t  upd;

  logic              slot_free;
  logic              load;
  logic [ADDR_W-1:0] addr_next;
  status_t           status_next;
  logic              ram_we;
  logic              ram_re;
  logic [LINK_W-1:0] link_rdata;
  logic [PN_W:0]     base_pn;
  logic [ADDR_W-1:0] pop_addr;

  pcpa_free_check u_check (
    .region_start (region_start),
    .region_end   (region_end),
    .page_addr    (addr_q),
    .chk          (chk)
  );

  pcpa_heads u_heads (
    .clk (clk),
    .rst (rst),
    .op  (op_q),
    .cpu (cpu_q),
    .upd (upd),
    .sel (sel)
  );

  pcpa_link_ram #(
    .DEPTH (NUM_PAGES),
    .WIDTH (LINK_W)
  ) u_links (
    .clk   (clk),
    .we    (ram_we),
    .waddr (chk.frame),
    .wdata ({sel.found, sel.frame}),
    .re    (ram_re),
    .raddr (sel.frame),
    .rdata (link_rdata)
  );

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    base_pn  = page_base(region_start);
    pop_addr = {base_pn[PN_W-1:0], PAGE_W'(0)} + ADDR_W'({pop_frame, PAGE_W'(0)});
  end

  always_comb begin
    state_next  = state;
    load        = 1'b0;
    addr_next   = '0;
    status_next = ST_OK;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    upd         = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op_q == OP_FREE) begin
          if (slot_free) begin
            load        = 1'b1;
            status_next = chk.ok ? ST_OK : ST_BAD_FREE;
            ram_we      = chk.ok;
            upd.push    = chk.ok;
            upd.cpu     = cpu_q;
            upd.frame   = chk.frame;
            state_next  = S_IDLE;
          end
        end else if (!sel.found) begin
          if (slot_free) begin
            load        = 1'b1;
            status_next = ST_EMPTY;
            state_next  = S_IDLE;
          end
        end else begin
          ram_re     = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (slot_free) begin
          load       = 1'b1;
          addr_next  = pop_addr;
          upd.pop    = 1'b1;
          upd.cpu    = pop_cpu;
          upd.valid  = link_rdata[LINK_W-1];
          upd.frame  = link_rdata[LINK_W-1] ? link_rdata[FRAME_W-1:0] : '0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (load) begin
      alloc_addr <= addr_next;
      status     <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q   <= op;
      cpu_q  <= cpu_reduce(cpu);
      addr_q <= page_addr;
    end
    if (ram_re) begin
      pop_cpu   <= sel.cpu;
      pop_frame <= sel.frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= REGION_START_RST;
      region_end   <= REGION_END_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_REGION_START: region_start <= cfg_wdata;
        REG_REGION_END:   region_end   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  a_err_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> alloc_addr == '0)
    else $error("error result carries a nonzero address");

  a_read_after_exec: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> $past(state) == S_EXEC || $past(state) == S_READ)
    else $error("link read state entered without a pending allocate");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in work");

endmodule

// ----- dv/per_cpu_page_free_list_allocator_test.sv -----
// Self-checking testbench of the per-CPU page allocator: directed and random traffic.
`timescale 1ns / 1ps

module per_cpu_page_free_list_allocator_test;
  import pcpa_pkg::*;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    status_t           st;
  } page_result_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [ADDR_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic                 op;
  logic [CPU_IN_W-1:0]  cpu;
  logic [ADDR_W-1:0]    page_addr;
  logic                 out_valid;
  logic                 out_ready;
  logic [ADDR_W-1:0]    alloc_addr;
  logic [STATUS_W-1:0]  status;

  logic [ADDR_W-1:0]  region_lo;
  logic [ADDR_W-1:0]  region_hi;
  logic [FRAME_W-1:0] list_top [NUM_CPUS];
  logic               list_top_ok [NUM_CPUS];
  logic [FRAME_W-1:0] frame_next [NUM_PAGES];
  logic               frame_next_ok [NUM_PAGES];

  page_result_t pending_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int page_span = 64;

  per_cpu_page_free_list_allocator dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .cpu(cpu), .page_addr(page_addr),
    .out_valid(out_valid), .out_ready(out_ready),
    .alloc_addr(alloc_addr), .status(status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The managed base is the region start rounded up to a page; bit 32 flags overflow.
  function automatic logic [ADDR_W:0] managed_base();
    logic [ADDR_W:0] s;
    s = {1'b0, region_lo} + (ADDR_W + 1)'(PAGE_BYTES - 1);
    s[PAGE_W-1:0] = '0;
    return s;
  endfunction

  function automatic page_result_t predict_page_op(logic opc, logic [CPU_IN_W-1:0] c,
                                                   logic [ADDR_W-1:0] a);
    page_result_t r;
    logic [ADDR_W:0] base;
    logic [ADDR_W:0] offs;
    logic [FRAME_W-1:0] fr;
    int unsigned ci;
    int sel;
    r.addr = '0;
    r.st = ST_OK;
    base = managed_base();
    ci = c % NUM_CPUS;
    if (opc == OP_FREE) begin
      offs = {1'b0, a} - base;
      if (a[PAGE_W-1:0] != '0 || a < region_lo || a >= region_hi || base[ADDR_W] ||
          {1'b0, a} < base || offs[ADDR_W:PAGE_W] >= NUM_PAGES) begin
        r.st = ST_BAD_FREE;
      end else begin
        fr = offs[PAGE_W+FRAME_W-1:PAGE_W];
        frame_next[fr] = list_top[ci];
        frame_next_ok[fr] = list_top_ok[ci];
        list_top[ci] = fr;
        list_top_ok[ci] = 1'b1;
      end
    end else begin
      sel = -1;
      if (list_top_ok[ci]) begin
        sel = ci;
      end else begin
        for (int i = 0; i < NUM_CPUS; i++) begin
          if (sel < 0 && i != ci && list_top_ok[i]) begin
            sel = i;
          end
        end
      end
      if (sel < 0) begin
        r.st = ST_EMPTY;
      end else begin
        fr = list_top[sel];
        list_top_ok[sel] = frame_next_ok[fr];
        list_top[sel] = frame_next_ok[fr] ? frame_next[fr] : '0;
        offs = base + ((ADDR_W + 1)'(fr) << PAGE_W);
        r.addr = offs[ADDR_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic void check_result();
    page_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, alloc_addr %h status %0d", $time, alloc_addr, status);
      errors++;
    end else begin
      want = pending_results.pop_front();
      if (alloc_addr !== want.addr) begin
        $display("%0t: alloc_addr expected %h actual %h", $time, want.addr, alloc_addr);
        errors++;
      end
      if (status !== want.st) begin
        $display("%0t: status expected %0d actual %0d", $time, want.st, status);
        errors++;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      check_result();
    end
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_request(logic opc, logic [CPU_IN_W-1:0] c, logic [ADDR_W-1:0] a);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= opc;
    cpu <= c;
    page_addr <= a;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_page_op(opc, c, a));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_region_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_REGION_START) begin
      region_lo = val;
    end else begin
      region_hi = val;
    end
  endtask

  task automatic set_region(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
    wait_idle();
    write_region_reg(REG_REGION_START, lo);
    write_region_reg(REG_REGION_END, hi);
  endtask

  function automatic logic [ADDR_W-1:0] pick_page();
    logic [ADDR_W:0] a;
    int unsigned fr;
    if ($urandom_range(0, 9) == 0) begin
      fr = $urandom_range(0, NUM_PAGES - 1);
    end else begin
      fr = $urandom_range(0, page_span - 1);
    end
    a = managed_base() + ((ADDR_W + 1)'(fr) << PAGE_W);
    return a[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] odd_address();
    logic [ADDR_W-1:0] a;
    case ($urandom_range(0, 4))
      0: a = $urandom();
      1: a = pick_page() | ADDR_W'($urandom_range(1, PAGE_BYTES - 1));
      2: a = region_lo - ADDR_W'(PAGE_BYTES);
      3: a = {region_hi[ADDR_W-1:PAGE_W], {PAGE_W{1'b0}}};
      default: a = {PN_W'($urandom_range(0, 2 ** PN_W - 1)), {PAGE_W{1'b0}}};
    endcase
    return a;
  endfunction

  task automatic send_random_request();
    logic opc;
    logic [ADDR_W-1:0] a;
    opc = ($urandom_range(0, 99) < 45) ? OP_ALLOC : OP_FREE;
    if (opc == OP_ALLOC) begin
      a = $urandom();
    end else if ($urandom_range(0, 99) < 80) begin
      a = pick_page();
    end else begin
      a = odd_address();
    end
    send_request(opc, CPU_IN_W'($urandom_range(0, 2 ** CPU_IN_W - 1)), a);
  endtask

  task automatic test_empty_lists();
    send_request(OP_ALLOC, 3'd0, 32'h0);
    send_request(OP_ALLOC, 3'd7, 32'hFFFF_FFFF);
  endtask

  task automatic test_free_checks();
    send_request(OP_FREE, 3'd1, 32'h8000_0000);
    send_request(OP_FREE, 3'd1, 32'h87FF_F000);
    send_request(OP_FREE, 3'd2, 32'h8000_0800);
    send_request(OP_FREE, 3'd2, 32'h7FFF_F000);
    send_request(OP_FREE, 3'd2, 32'h8800_0000);
    send_request(OP_FREE, 3'd3, 32'hFFFF_FFFF);
    send_request(OP_FREE, 3'd3, 32'h0000_0000);
  endtask

  task automatic test_lifo_and_steal();
    send_request(OP_ALLOC, 3'd1, 32'h0);
    send_request(OP_FREE, 3'd6, 32'h8000_5000);
    send_request(OP_FREE, 3'd4, 32'h8000_3000);
    send_request(OP_ALLOC, 3'd2, 32'h0);
    send_request(OP_ALLOC, 3'd2, 32'h0);
    send_request(OP_ALLOC, 3'd6, 32'h0);
    send_request(OP_ALLOC, 3'd3, 32'h0);
  endtask

  task automatic test_capacity_limit();
    set_region(32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_FREE, 3'd0, 32'h07FF_F000);
    send_request(OP_FREE, 3'd0, 32'h0800_0000);
    send_request(OP_FREE, 3'd7, 32'h0000_0000);
  endtask

  // Pages stay listed by frame while the region moves under them.
  task automatic test_region_change();
    set_region(32'h0000_0801, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, 3'd0, 32'h0);
    set_region(32'hFFFF_F001, 32'h0000_0000);
    send_request(OP_FREE, 3'd5, 32'hFFFF_F000);
    send_request(OP_ALLOC, 3'd7, 32'h0);
    set_region(32'hFFFF_F000, 32'hFFFF_FFFF);
    send_request(OP_FREE, 3'd3, 32'hFFFF_F000);
    send_request(OP_ALLOC, 3'd3, 32'h0);
  endtask

  task automatic test_random_traffic(int count, int idle_pct, int stall_pct, int span);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    page_span = span;
    repeat (count) send_random_request();
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_output_backpressure();
    set_region(32'h4000_0000, 32'h4004_0000);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    page_span = 64;
    hold_request = 400;
    repeat (30) send_random_request();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = REG_REGION_START;
    cfg_wdata = '0;
    in_valid = 1'b0;
    op = OP_ALLOC;
    cpu = '0;
    page_addr = '0;
    out_ready = 1'b0;
    region_lo = REGION_START_RST;
    region_hi = REGION_END_RST;
    for (int i = 0; i < NUM_CPUS; i++) begin
      list_top[i] = '0;
      list_top_ok[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_empty_lists();
    test_free_checks();
    test_lifo_and_steal();
    test_capacity_limit();
    test_region_change();

    set_region(REGION_START_RST, REGION_END_RST);
    test_random_traffic(300, 0, 0, 64);
    set_region(32'h0000_0000, 32'hFFFF_FFFF);
    test_random_traffic(300, 70, 0, 64);
    set_region(32'h0001_0801, 32'h0200_0000);
    test_random_traffic(300, 0, 70, 64);
    set_region(32'hFFFF_0000, 32'hFFFF_FFFF);
    test_random_traffic(150, 37, 37, 16);
    set_region(REGION_START_RST, REGION_END_RST);
    test_random_traffic(300, 37, 37, 64);
    test_output_backpressure();
    test_random_traffic(150, 0, 0, 64);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/pcpa_pkg.sv
rtl/core/pcpa_link_ram.sv
rtl/core/pcpa_free_check.sv
rtl/core/pcpa_heads.sv
rtl/core/per_cpu_page_free_list_allocator.sv
dv/per_cpu_page_free_list_allocator_test.sv
